/* hw/rtl/asrb_pkg.sv */
// Shared types and constants of the axis sum reduce and broadcast block.
package asrb_pkg;

  localparam int unsigned StoreDepth = 4096;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  localparam int unsigned OpW     = 3;
  localparam int unsigned PosW    = 16;
  localparam int unsigned ValW    = 48;
  localparam int unsigned EntryW  = 12;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SlabW   = 2 * CfgW;
  localparam int unsigned CntW    = $clog2(PosW);

  localparam logic [CfgIdxW-1:0] RegReduceLen = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInnerSize = 2'd1;

  typedef enum logic [OpW-1:0] {
    OpClear      = 3'd0,
    OpAccumulate = 3'd1,
    OpRead       = 3'd2,
    OpWrite      = 3'd3,
    OpBroadcast  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StDiv,
    StMul,
    StAddr,
    StRead,
    StResp
  } state_e;

endpackage

/* hw/rtl/axis_sum_reduce_broadcast_top.sv */
// Top level of the axis sum reduce and broadcast block: sum store and its sequencer.
//
//   Channel   Signals                                         Direction
//   --------  ----------------------------------------------  ---------
//   request   in_valid_i/in_ready_o, operation_i, position_i,  in
//             value_i
//   result    out_valid_o/out_ready_i, result_value_o,        out
//             entry_index_o
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i                 in
//
// Clear and write finish in the cycle they are taken; read passes the read and
// response states. Accumulate and broadcast read first map an element index onto a
// store entry with a 16-step restoring divider, a multiply and an add, then read.
// One request is in flight at a time. A result waiting in the output register
// holds the sequencer only when a further result is ready to replace it.
// Reset clears control state and the config registers; the store is not cleared.
module axis_sum_reduce_broadcast_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [asrb_pkg::OpW-1:0]     operation_i,
  input  logic [asrb_pkg::PosW-1:0]    position_i,
  input  logic signed [asrb_pkg::ValW-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [asrb_pkg::ValW-1:0] result_value_o,
  output logic [asrb_pkg::EntryW-1:0]  entry_index_o,
  input  logic                         cfg_we_i,
  input  logic [asrb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [asrb_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned AddrW  = asrb_pkg::AddrW;
  localparam int unsigned PosW   = asrb_pkg::PosW;
  localparam int unsigned ValW   = asrb_pkg::ValW;
  localparam int unsigned CfgW   = asrb_pkg::CfgW;
  localparam int unsigned SlabW  = asrb_pkg::SlabW;
  localparam int unsigned CntW   = asrb_pkg::CntW;

  asrb_pkg::state_e state_q, state_d;
  asrb_pkg::op_e    op_in;
  asrb_pkg::op_e    op_q;

  logic [CfgW-1:0]  reduce_len_q, inner_size_q;
  logic [CfgW-1:0]  r_eff, n_eff;

  logic [PosW-1:0]  pos_q;
  logic signed [ValW-1:0] val_q;
  logic [SlabW-1:0] slab_q;
  logic [PosW-1:0]  dvd_q, quo_q, rem1_q, rem2_q;
  logic [CntW-1:0]  cnt_q;
  logic [AddrW-1:0] prod_q, addr_q;
  logic signed [ValW-1:0] rd_q;

  logic             out_valid_q;
  logic signed [ValW-1:0] result_value_q;
  logic [asrb_pkg::EntryW-1:0] entry_index_q;

  logic [ValW-1:0]  sum_mem [asrb_pkg::StoreDepth];
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [ValW-1:0]  wr_data;
  logic             rd_en;
  logic             out_load;
  logic             in_acc;

  logic [PosW:0]    trial1, trial2;
  logic             ge1, ge2;
  logic [SlabW-1:0] sub1;
  logic [CfgW-1:0]  sub2;
  logic signed [ValW:0] sum_wide;
  logic [ValW-1:0]  sum_sat;

  assign op_in  = asrb_pkg::op_e'(operation_i);
  assign in_acc = in_valid_i && in_ready_o;

  // A register value of zero behaves as one.
  assign r_eff = (reduce_len_q == '0) ? CfgW'(1) : reduce_len_q;
  assign n_eff = (inner_size_q == '0) ? CfgW'(1) : inner_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reduce_len_q <= CfgW'(1);
      inner_size_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == asrb_pkg::RegReduceLen) begin
        reduce_len_q <= cfg_wdata_i;
      end else if (cfg_idx_i == asrb_pkg::RegInnerSize) begin
        inner_size_q <= cfg_wdata_i;
      end
    end
  end

  // One restoring step each for the slab quotient and the inner remainder.
  // The partial remainders never exceed the 16-bit dividend prefix.
  assign trial1 = {rem1_q, dvd_q[PosW-1]};
  assign trial2 = {rem2_q, dvd_q[PosW-1]};
  assign ge1    = {{(SlabW-PosW-1){1'b0}}, trial1} >= slab_q;
  assign ge2    = trial2 >= n_eff;
  assign sub1   = {{(SlabW-PosW-1){1'b0}}, trial1} - slab_q;
  assign sub2   = trial2 - n_eff;

  assign sum_wide = {rd_q[ValW-1], rd_q} + {val_q[ValW-1], val_q};
  always_comb begin
    if (sum_wide[ValW] != sum_wide[ValW-1]) begin
      sum_sat = sum_wide[ValW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ValW-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = addr_q;
    wr_data    = sum_sat;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      asrb_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op_in)
            asrb_pkg::OpClear: begin
              wr_en   = 1'b1;
              wr_addr = position_i[AddrW-1:0];
              wr_data = '0;
            end
            asrb_pkg::OpWrite: begin
              wr_en   = 1'b1;
              wr_addr = position_i[AddrW-1:0];
              wr_data = value_i;
            end
            asrb_pkg::OpRead: begin
              state_d = asrb_pkg::StRead;
            end
            asrb_pkg::OpAccumulate, asrb_pkg::OpBroadcast: begin
              state_d = asrb_pkg::StPrep;
            end
            default: begin
              state_d = asrb_pkg::StIdle;
            end
          endcase
        end
      end
      asrb_pkg::StPrep: state_d = asrb_pkg::StDiv;
      asrb_pkg::StDiv: begin
        if (cnt_q == CntW'(PosW - 1)) begin
          state_d = asrb_pkg::StMul;
        end
      end
      asrb_pkg::StMul:  state_d = asrb_pkg::StAddr;
      asrb_pkg::StAddr: state_d = asrb_pkg::StRead;
      asrb_pkg::StRead: begin
        rd_en   = 1'b1;
        state_d = asrb_pkg::StResp;
      end
      asrb_pkg::StResp: begin
        if (op_q == asrb_pkg::OpAccumulate) begin
          wr_en   = 1'b1;
          state_d = asrb_pkg::StIdle;
        end else if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = asrb_pkg::StIdle;
        end
      end
      default: state_d = asrb_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asrb_pkg::StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == asrb_pkg::StDiv) begin
        cnt_q <= cnt_q + CntW'(1);
      end else begin
        cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_in;
      pos_q  <= position_i;
      val_q  <= value_i;
      addr_q <= position_i[AddrW-1:0];
    end
    case (state_q)
      asrb_pkg::StPrep: begin
        slab_q <= SlabW'({{(SlabW-CfgW){1'b0}}, r_eff} * {{(SlabW-CfgW){1'b0}}, n_eff});
        dvd_q  <= pos_q;
        quo_q  <= '0;
        rem1_q <= '0;
        rem2_q <= '0;
      end
      asrb_pkg::StDiv: begin
        dvd_q  <= {dvd_q[PosW-2:0], 1'b0};
        quo_q  <= {quo_q[PosW-2:0], ge1};
        rem1_q <= ge1 ? sub1[PosW-1:0] : trial1[PosW-1:0];
        rem2_q <= ge2 ? sub2[PosW-1:0] : trial2[PosW-1:0];
      end
      asrb_pkg::StMul: begin
        prod_q <= AddrW'(quo_q[AddrW-1:0] * n_eff[AddrW-1:0]);
      end
      asrb_pkg::StAddr: begin
        addr_q <= prod_q + rem2_q[AddrW-1:0];
      end
      default: begin
      end
    endcase
    if (out_load) begin
      result_value_q <= rd_q;
      entry_index_q  <= asrb_pkg::EntryW'(addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sum_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= sum_mem[addr_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_value_q;
  assign entry_index_o  = entry_index_q;

endmodule

/* hw/rtl/asrb_checker.sv */
// Port-level checker for the axis sum reduce and broadcast block, with its bind.
module asrb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [asrb_pkg::OpW-1:0]     operation_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [asrb_pkg::ValW-1:0]    result_value_o,
  input logic [asrb_pkg::EntryW-1:0]  entry_index_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o)
      && $stable(entry_index_o))
    else $error("result changed while stalled");

  // Clear and write finish in the cycle they are taken.
  a_store_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o
      && (operation_i == asrb_pkg::OpClear || operation_i == asrb_pkg::OpWrite)
      |=> in_ready_o)
    else $error("store request did not finish in one cycle");

  // A read keeps the request side closed through its read and response steps.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == asrb_pkg::OpRead
      |=> !in_ready_o ##1 !in_ready_o)
    else $error("request taken during a read");

  // A new result appears only from the response step, never while idle.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised while idle");

endmodule

bind axis_sum_reduce_broadcast_top asrb_checker u_asrb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .operation_i    (operation_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_value_o (result_value_o),
  .entry_index_o  (entry_index_o)
);
